// File: design/jit_pkg.sv
package jit_pkg;

    // widths of the configuration port and payload
    localparam int DATA_W      = 32;
    localparam int MIN_W       = 31;
    localparam int JIT_W       = 5;
    localparam int CFG_INDEX_W = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t REG_SEED         = 2'd0;
    localparam cfg_index_t REG_MIN_INTERVAL = 2'd1;
    localparam cfg_index_t REG_JITTER_BITS  = 2'd2;

    // register reset values
    localparam logic [DATA_W-1:0] SEED_RESET         = 32'd0;
    localparam logic [MIN_W-1:0]  MIN_INTERVAL_RESET = 31'd3000000;
    localparam logic [JIT_W-1:0]  JITTER_BITS_RESET  = 5'd22;

    // mulberry32 constants
    localparam logic [DATA_W-1:0] GOLDEN_STEP = 32'h6D2B79F5;
    localparam logic [DATA_W-1:0] ODD_MASK    = 32'd1;
    localparam logic [DATA_W-1:0] MIX_MASK    = 32'd61;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // input transaction accepted: decide and advance state
        logic mul1;     // first multiply of the mixer
        logic mul2;     // second multiply of the mixer
        logic finish;   // form the result and load the output register
    } jit_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic fire;     // elapsed time reached the interval for the item on the port
    } jit_sts_t;

endpackage

// File: design/jit_ctrl.sv
module jit_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  jit_pkg::jit_sts_t  sts,
    output jit_pkg::jit_cmd_t  cmd
);
    import jit_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // output slot can take a new result
    assign slot_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state, commands and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.fire ? ST_MUL1 : ST_FIN;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/jit_dp.sv
module jit_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  jit_pkg::cfg_index_t          cfg_index,
    input  logic [jit_pkg::DATA_W-1:0]   cfg_data,
    input  logic [jit_pkg::DATA_W-1:0]   now,
    input  jit_pkg::jit_cmd_t            cmd,
    output jit_pkg::jit_sts_t            sts,
    output logic                         fire,
    output logic [jit_pkg::DATA_W-1:0]   interval,
    output logic [jit_pkg::DATA_W-1:0]   random_word
);
    import jit_pkg::*;

    // configuration and timer state
    logic [MIN_W-1:0]  min_reg;
    logic [JIT_W-1:0]  jit_reg;
    logic [DATA_W-1:0] gen_reg;
    logic [DATA_W-1:0] last_reg;
    logic [DATA_W-1:0] intv_reg;
    logic              fire_reg;

    // mixer products
    logic [DATA_W-1:0] prod1_reg;
    logic [DATA_W-1:0] prod2_reg;

    // output register
    logic              out_fire_reg;
    logic [DATA_W-1:0] out_intv_reg;
    logic [DATA_W-1:0] out_word_reg;

    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W-1:0] mul_p;
    logic [DATA_W-1:0] mix_sum;
    logic [DATA_W-1:0] mix_z;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] new_intv;

    // interval check for the item on the input port
    assign elapsed  = now - last_reg;
    assign sts.fire = (elapsed >= intv_reg);

    // shared multiplier, low 32 bits of the product
    always_comb
    begin
        if (cmd.mul2)
        begin
            mul_a = prod1_reg ^ (prod1_reg >> 7);
            mul_b = prod1_reg | MIX_MASK;
        end
        else
        begin
            mul_a = gen_reg ^ (gen_reg >> 15);
            mul_b = gen_reg | ODD_MASK;
        end
    end
    assign mul_p = DATA_W'(mul_a * mul_b);

    // final mix and new interval
    assign mix_sum  = prod1_reg + prod2_reg;
    assign mix_z    = prod1_reg ^ mix_sum;
    assign word     = mix_z ^ (mix_z >> 14);
    assign mask     = (DATA_W'(1) << jit_reg) - DATA_W'(1);
    assign new_intv = {1'b0, min_reg} + (word & mask);

    // configuration and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= MIN_INTERVAL_RESET;
            jit_reg  <= JITTER_BITS_RESET;
            gen_reg  <= SEED_RESET;
            last_reg <= '0;
            intv_reg <= '0;
            fire_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SEED:         gen_reg <= cfg_data;
                    REG_MIN_INTERVAL: min_reg <= cfg_data[MIN_W-1:0];
                    REG_JITTER_BITS:  jit_reg <= cfg_data[JIT_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.load)
            begin
                fire_reg <= sts.fire;
                if (sts.fire)
                begin
                    last_reg <= now;
                    gen_reg  <= gen_reg + GOLDEN_STEP;
                end
            end
            if (cmd.finish && fire_reg)
            begin
                intv_reg <= new_intv;
            end
        end
    end

    // mixer product registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            prod1_reg <= mul_p;
        end
        if (cmd.mul2)
        begin
            prod2_reg <= mul_p;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_fire_reg <= fire_reg;
            out_intv_reg <= fire_reg ? new_intv : intv_reg;
            out_word_reg <= fire_reg ? word : '0;
        end
    end

    assign fire        = out_fire_reg;
    assign interval    = out_intv_reg;
    assign random_word = out_word_reg;

endmodule

// File: design/jittered_interval_timer_top.sv
// Jittered interval timer.
// Input channel (in_valid/in_ready, field now) carries the free-running time.
// Each transaction yields one result transaction (out_valid/out_ready) with
// fire, the interval in force after the item and the random word drawn.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, the block itself does not enforce it;
// writing the seed reloads the generator.
// When the timer fires, an accepted item passes through MUL1 and MUL2
// (two passes through the shared 32x32 multiplier), then FIN (the final
// mix); when it does not fire it goes straight to FIN. One item is in the
// datapath at a time: no new item is accepted until the last one leaves FIN.
// The result sits in an output register: a new item may be accepted while
// the previous result still waits, but a finished item waits in the last
// step until the receiver takes the pending result.
// Reset clears the timer: the interval is zero so the first item fires, the
// generator holds the seed reset value and the result channel is empty.
module jittered_interval_timer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  jit_pkg::cfg_index_t          cfg_index,
    input  logic [jit_pkg::DATA_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [jit_pkg::DATA_W-1:0]   now,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         fire,
    output logic [jit_pkg::DATA_W-1:0]   interval,
    output logic [jit_pkg::DATA_W-1:0]   random_word
);
    import jit_pkg::*;

    jit_cmd_t cmd;
    jit_sts_t sts;

    // controller
    jit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    jit_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .now         (now),
        .cmd         (cmd),
        .sts         (sts),
        .fire        (fire),
        .interval    (interval),
        .random_word (random_word)
    );

    // one item at a time in the datapath
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // no draw without a firing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fire |-> random_word == '0)
        else $error("random word nonzero on a result that did not fire");

    // a new result appears only after the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish))
        else $error("result valid without a finish step");

endmodule

// File: test/interval_timer_checker.sv
`timescale 1ns / 1ps

module interval_timer_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  jit_pkg::cfg_index_t          cfg_index,
    input  logic [jit_pkg::DATA_W-1:0]   cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [jit_pkg::DATA_W-1:0]   now,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         fire,
    input  logic [jit_pkg::DATA_W-1:0]   interval,
    input  logic [jit_pkg::DATA_W-1:0]   random_word,
    output int                           errors,
    output int                           pending
);
    import jit_pkg::*;

    typedef struct packed {
        logic              fire;
        logic [DATA_W-1:0] interval;
        logic [DATA_W-1:0] random_word;
    } timer_result_t;

    // results still owed by the block, oldest first
    timer_result_t expected_results[$];
    timer_result_t oldest;

    // shadow copy of the registers and timer state
    logic [MIN_W-1:0]  min_reg;
    logic [JIT_W-1:0]  jit_reg;
    logic [DATA_W-1:0] gen_state;
    logic [DATA_W-1:0] last_fire;
    logic [DATA_W-1:0] cur_interval;

    initial errors = 0;
    initial pending = 0;

    // mulberry32 output mix of an already advanced generator state
    function automatic logic [DATA_W-1:0] mulberry_mix(input logic [DATA_W-1:0] st);
        logic [DATA_W-1:0] z;
        z = st;
        z = (z ^ (z >> 15)) * (z | ODD_MASK);
        z = z ^ (z + (z ^ (z >> 7)) * (z | MIX_MASK));
        return z ^ (z >> 14);
    endfunction

    // decide on one time sample and advance the timer state
    function automatic timer_result_t predict_tick(input logic [DATA_W-1:0] t);
        timer_result_t     r;
        logic [DATA_W-1:0] mask;
        r = '0;
        if (t - last_fire >= cur_interval)
        begin
            mask          = (32'd1 << jit_reg) - 32'd1;
            last_fire     = t;
            gen_state     = gen_state + GOLDEN_STEP;
            r.fire        = 1'b1;
            r.random_word = mulberry_mix(gen_state);
            cur_interval  = {1'b0, min_reg} + (r.random_word & mask);
        end
        r.interval = cur_interval;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      = MIN_INTERVAL_RESET;
            jit_reg      = JITTER_BITS_RESET;
            gen_state    = SEED_RESET;
            last_fire    = '0;
            cur_interval = '0;
            expected_results.delete();
            pending      = 0;
        end
        else
        begin
            // register write, indexes past the last register are dropped
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SEED:         gen_state = cfg_data;
                    REG_MIN_INTERVAL: min_reg   = cfg_data[MIN_W-1:0];
                    REG_JITTER_BITS:  jit_reg   = cfg_data[JIT_W-1:0];
                    default:          ;
                endcase
            end

            // result transaction against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with none owed: fire %0d interval %0h word %0h",
                           fire, interval, random_word);
                    errors++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (fire !== oldest.fire)
                    begin
                        $error("fire: expected %0d, actual %0d", oldest.fire, fire);
                        errors++;
                    end
                    if (interval !== oldest.interval)
                    begin
                        $error("interval: expected %0h, actual %0h", oldest.interval, interval);
                        errors++;
                    end
                    if (random_word !== oldest.random_word)
                    begin
                        $error("random_word: expected %0h, actual %0h",
                               oldest.random_word, random_word);
                        errors++;
                    end
                end
            end

            // input transaction
            if (in_valid && in_ready)
                expected_results.push_back(predict_tick(now));

            pending = expected_results.size();
        end
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import jit_pkg::*;

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         PHASE_ITEMS   = 150;
    localparam int         SETTLE_CYCLES = 4;
    localparam cfg_index_t REG_UNUSED    = 2'd3;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_write   = 1'b0;
    cfg_index_t        cfg_index   = REG_SEED;
    logic [DATA_W-1:0] cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] now         = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic              fire;
    logic [DATA_W-1:0] interval;
    logic [DATA_W-1:0] random_word;

    int errors;
    int pending;
    int cycle_count = 0;

    // stimulus side view of the timer settings
    logic [DATA_W-1:0] t_now     = '0;
    logic [MIN_W-1:0]  drive_min = MIN_INTERVAL_RESET;
    logic [JIT_W-1:0]  drive_jit = JITTER_BITS_RESET;
    int                burst_left = 0;

    // receiver stall pattern state
    int stall_mode = 0;
    int stall_left = 0;

    logic [DATA_W-1:0] corner_times [11] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
        32'h002D_C6C0
    };

    jittered_interval_timer_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now         (now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fire        (fire),
        .interval    (interval),
        .random_word (random_word)
    );

    interval_timer_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now         (now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fire        (fire),
        .interval    (interval),
        .random_word (random_word),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: runs of always ready, random stalls and long stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 96);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // one register write per cycle; caller lowers cfg_write after the last one
    task automatic cfg_put(input cfg_index_t idx, input logic [DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_timer(input logic [DATA_W-1:0] seed_val,
                                 input logic [DATA_W-1:0] min_val,
                                 input logic [DATA_W-1:0] jit_val);
        cfg_put(REG_SEED, seed_val);
        cfg_put(REG_MIN_INTERVAL, min_val);
        cfg_put(REG_JITTER_BITS, jit_val);
        cfg_write <= 1'b0;
        drive_min = min_val[MIN_W-1:0];
        drive_jit = jit_val[JIT_W-1:0];
    endtask

    // one input transaction, sent in bursts with random gaps between them
    task automatic send_time(input logic [DATA_W-1:0] t);
        int   gap;
        logic rdy;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        now      <= t;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
    endtask

    // time samples: small steps, steps around the threshold, sure fires and wild jumps
    task automatic send_random_times(input int count);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] base;
        repeat (count)
        begin
            mask = (32'd1 << drive_jit) - 32'd1;
            base = {1'b0, drive_min};
            case ($urandom_range(0, 9))
                0, 1, 2:    t_now = t_now + $urandom_range(0, 3);
                3, 4, 5, 6: t_now = t_now + base + ($urandom & mask);
                7, 8:       t_now = t_now + base + mask + 32'd1;
                default:    t_now = $urandom;
            endcase
            send_time(t_now);
        end
    endtask

    // stop sending and let every owed result come back
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("jittered_interval_timer_top: mismatch");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first sample fires, wrap of elapsed time, bit patterns
        foreach (corner_times[i])
            send_time(corner_times[i]);
        t_now = corner_times[10];
        send_random_times(PHASE_ITEMS);
        drain();

        // no minimum and no jitter: every sample fires
        program_timer(32'hFFFF_FFFF, 32'h0, 32'h0);
        send_random_times(PHASE_ITEMS);
        drain();

        // bits above the register widths: widest minimum and jitter of 31 bits
        program_timer($urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_random_times(PHASE_ITEMS);
        drain();

        // write to an index past the registers, then seed zero
        cfg_put(REG_UNUSED, $urandom);
        program_timer(32'h0, 32'h1, 32'd30);
        send_random_times(PHASE_ITEMS);
        drain();

        // short intervals with modest jitter
        program_timer($urandom, $urandom_range(0, 1000), $urandom_range(0, 12));
        send_random_times(PHASE_ITEMS);
        drain();

        // unrestricted register data
        program_timer($urandom, $urandom, $urandom);
        send_random_times(PHASE_ITEMS);
        drain();

        if (errors == 0)
            $display("jittered_interval_timer_top: match");
        else
            $display("jittered_interval_timer_top: mismatch");
        $finish;
    end

endmodule
